// ===== sv/dxt_block_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Shorthand for concurrent checks on clk, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_DEFINES_SVH
`define DXT_BLOCK_DECODER_DEFINES_SVH

// check that is off while rst_n is low
`define DXTBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define DXTBD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dxtbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dxtbd_pkg
// Shared types and constants of the DXT block decoder.
// ----------------------------------------------------------------------------
package dxtbd_pkg;

  // block_format codes; the unused code decodes as color only
  localparam logic [1:0] FMT_COLOR    = 2'd0;
  localparam logic [1:0] FMT_EXPLICIT = 2'd1;
  localparam logic [1:0] FMT_INTERP   = 2'd2;

  localparam int BQ_DEPTH    = 2;  // block queue between front and back
  localparam int OFIFO_DEPTH = 4;  // result queue

  // one classified block, channels ordered {r, g, b}
  typedef struct packed {
    logic [1:0]            fmt;
    logic                  four_color;   // endpoint0 > endpoint1
    logic                  alpha_seven;  // alpha0 > alpha1
    logic [2:0][7:0]       c0;
    logic [2:0][7:0]       c1;
    logic [31:0]           cidx;
    logic [63:0]           ablk;
  } blk_t;

endpackage

// ===== sv/dxtbd_front.sv =====
// ----------------------------------------------------------------------------
// dxtbd_front
// Accepts compressed blocks, widens endpoints, classifies palette modes and
// holds the result in a short block queue for the back end.
// ----------------------------------------------------------------------------
module dxtbd_front import dxtbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  block_format,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_color_block,
  input  logic [63:0] in_alpha_block,
  output logic        head_valid,
  output blk_t        head,
  input  logic        head_pop
);

  blk_t                      q_r [BQ_DEPTH];
  logic [$clog2(BQ_DEPTH)-1:0] wr_ptr_r, rd_ptr_r;
  logic [$clog2(BQ_DEPTH):0]   cnt_r;
  blk_t                      cls;
  logic                      wr_en, rd_en;
  logic [15:0]               e0, e1;

  assign e0 = in_color_block[15:0];
  assign e1 = in_color_block[31:16];

  always_comb begin
    cls.fmt         = (block_format == FMT_EXPLICIT || block_format == FMT_INTERP) ?
                      block_format : FMT_COLOR;
    cls.four_color  = e0 > e1;
    cls.alpha_seven = in_alpha_block[7:0] > in_alpha_block[15:8];
    cls.c0[2]       = {e0[15:11], 3'b000};
    cls.c0[1]       = {e0[10:5], 2'b00};
    cls.c0[0]       = {e0[4:0], 3'b000};
    cls.c1[2]       = {e1[15:11], 3'b000};
    cls.c1[1]       = {e1[10:5], 2'b00};
    cls.c1[0]       = {e1[4:0], 3'b000};
    cls.cidx        = in_color_block[63:32];
    cls.ablk        = in_alpha_block;
  end

  assign full       = cnt_r == ($clog2(BQ_DEPTH)+1)'(BQ_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = q_r[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_ptr_r] <= cls;
  end

endmodule

// ===== sv/dxtbd_back.sv =====
// ----------------------------------------------------------------------------
// dxtbd_back
// Walks the 16 pixels of the head block: selects palette weights, divides
// by the palette constant and queues pixels for the result port.
// ----------------------------------------------------------------------------
module dxtbd_back import dxtbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  blk_t        head,
  output logic        head_pop,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_pixel_argb,
  output logic [1:0]  out_pixel_row,
  output logic [1:0]  out_pixel_col,
  output logic        out_last_pixel
);

  typedef enum logic [1:0] {CD_ONE, CD_TWO, CD_THREE} cdiv_t;
  typedef enum logic [1:0] {AD_ONE, AD_FIVE, AD_SEVEN} adiv_t;

  typedef struct packed {
    logic [31:0] argb;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
  } opix_t;

  localparam int OPW = $clog2(OFIFO_DEPTH);

  // reciprocals scaled by 2^14, exact for the numerator ranges used here
  localparam logic [12:0] RCP3 = 13'd5462;
  localparam logic [11:0] RCP5 = 12'd3277;
  localparam logic [11:0] RCP7 = 12'd2341;

  logic [3:0]        pix_r;
  logic              issue;
  logic [1:0]        ci;
  logic [2:0]        ai;
  logic [3:0]        nib;
  logic [2:0][9:0]   cnum;
  cdiv_t             cdiv;
  logic [10:0]       anum;
  adiv_t             adiv;
  logic [2:0]        wa, wb;

  logic              s1_v_r;
  logic [2:0][9:0]   s1_cnum_r;
  cdiv_t             s1_cdiv_r;
  logic [10:0]       s1_anum_r;
  adiv_t             s1_adiv_r;
  logic [3:0]        s1_pix_r;

  logic [2:0][7:0]   cq;
  logic [7:0]        aq;
  logic [22:0]       cprod [3];
  logic [22:0]       aprod;
  opix_t             wpix;

  opix_t             of_r [OFIFO_DEPTH];
  logic [OPW-1:0]    of_wr_r, of_rd_r;
  logic [OPW:0]      of_cnt_r;
  logic              of_rd;

  // room for the pixel in flight and the new one
  assign issue    = head_valid &&
                    ((of_cnt_r + (OPW+1)'(s1_v_r)) < (OPW+1)'(OFIFO_DEPTH));
  assign head_pop = issue && (pix_r == 4'd15);

  assign ci  = head.cidx[{pix_r, 1'b0} +: 2];
  assign ai  = head.ablk[16 + 3 * pix_r +: 3];
  assign nib = head.ablk[{pix_r, 2'b00} +: 4];

  always_comb begin
    cdiv = CD_ONE;
    for (int k = 0; k < 3; k++) begin
      case (ci)
        2'd0: cnum[k] = {2'b00, head.c0[k]};
        2'd1: cnum[k] = {2'b00, head.c1[k]};
        2'd2: cnum[k] = head.four_color ?
                        {1'b0, head.c0[k], 1'b0} + {2'b00, head.c1[k]} :
                        {2'b00, head.c0[k]} + {2'b00, head.c1[k]};
        2'd3: cnum[k] = head.four_color ?
                        {2'b00, head.c0[k]} + {1'b0, head.c1[k], 1'b0} : '0;
        default: cnum[k] = '0;
      endcase
    end
    if (ci == 2'd2) cdiv = head.four_color ? CD_THREE : CD_TWO;
    else if (ci == 2'd3 && head.four_color) cdiv = CD_THREE;
  end

  // alpha: explicit nibble, or palette entries 2..7 = (w0*a0 + w1*a1) / 7, or 2..5 / 5 with 6 = 0, 7 = 255
  always_comb begin
    wa   = '0;
    wb   = '0;
    adiv = AD_ONE;
    anum = '0;
    case (head.fmt)
      FMT_EXPLICIT: anum = {3'b000, nib, nib};
      FMT_INTERP: begin
        if (ai == 3'd0) anum = {3'b000, head.ablk[7:0]};
        else if (ai == 3'd1) anum = {3'b000, head.ablk[15:8]};
        else if (head.alpha_seven) begin
          wa   = 3'(4'd8 - {1'b0, ai});
          wb   = ai - 3'd1;
          adiv = AD_SEVEN;
          anum = 11'(wa * head.ablk[7:0]) + 11'(wb * head.ablk[15:8]);
        end else if (ai == 3'd6) anum = '0;
        else if (ai == 3'd7) anum = 11'd255;
        else begin
          wa   = 3'(4'd6 - {1'b0, ai});
          wb   = ai - 3'd1;
          adiv = AD_FIVE;
          anum = 11'(wa * head.ablk[7:0]) + 11'(wb * head.ablk[15:8]);
        end
      end
      default: anum = (!head.four_color && ci == 2'd3) ? 11'd0 : 11'd255;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      if (issue) pix_r <= pix_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cnum_r <= cnum;
      s1_cdiv_r <= cdiv;
      s1_anum_r <= anum;
      s1_adiv_r <= adiv;
      s1_pix_r  <= pix_r;
    end
  end

  // constant division by reciprocal multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cprod[k] = 23'(s1_cnum_r[k]) * 23'(RCP3);
      case (s1_cdiv_r)
        CD_TWO:   cq[k] = s1_cnum_r[k][8:1];
        CD_THREE: cq[k] = cprod[k][21:14];
        default:  cq[k] = s1_cnum_r[k][7:0];
      endcase
    end
    aprod = 23'(s1_anum_r) * ((s1_adiv_r == AD_SEVEN) ? 23'(RCP7) : 23'(RCP5));
    case (s1_adiv_r)
      AD_FIVE, AD_SEVEN: aq = aprod[21:14];
      default:           aq = s1_anum_r[7:0];
    endcase
    wpix.argb = {aq, cq[2], cq[1], cq[0]};
    wpix.row  = s1_pix_r[3:2];
    wpix.col  = s1_pix_r[1:0];
    wpix.last = s1_pix_r == 4'd15;
  end

  assign empty = of_cnt_r == '0;
  assign of_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= '0;
      of_rd_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      if (s1_v_r) of_wr_r <= of_wr_r + 1'b1;
      if (of_rd) of_rd_r <= of_rd_r + 1'b1;
      if (s1_v_r && !of_rd) of_cnt_r <= of_cnt_r + 1'b1;
      else if (of_rd && !s1_v_r) of_cnt_r <= of_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) of_r[of_wr_r] <= wpix;
  end

  assign out_pixel_argb = of_r[of_rd_r].argb;
  assign out_pixel_row  = of_r[of_rd_r].row;
  assign out_pixel_col  = of_r[of_rd_r].col;
  assign out_last_pixel = of_r[of_rd_r].last;

endmodule

// ===== sv/dxt_block_decoder.sv =====
// ----------------------------------------------------------------------------
// dxt_block_decoder
// DXT1/DXT3/DXT5 4x4 block decoder: one compressed block in, 16 ARGB8888
// pixels out in row-major order.
//
//   channel   ports                                  handshake
//   input     in_color_block, in_alpha_block         push / full
//   result    out_pixel_argb/_row/_col/_last_pixel   empty / pop
//   config    cfg_wdata (block_format)               cfg_we
//
// Each block yields one pixel per cycle while the pixel queue has room, set by
// the back end's single pixel lane, via block queue, stage 1 and pixel queue.
// The 2-entry block queue holds the block in work plus one waiting, so a
// push is taken while the back end works.
// A stalled result port backs up a 4-deep pixel queue, then the block queue.
// Synchronous reset empties both queues and sets block_format to color only.
// ----------------------------------------------------------------------------
module dxt_block_decoder import dxtbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_color_block,
  input  logic [63:0] in_alpha_block,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_pixel_argb,
  output logic [1:0]  out_pixel_row,
  output logic [1:0]  out_pixel_col,
  output logic        out_last_pixel
);

  logic [1:0] block_format_r;
  logic       head_valid;
  logic       head_pop;
  blk_t       head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r <= FMT_COLOR;
    end else if (cfg_we) begin
      block_format_r <= cfg_wdata;
    end
  end

  dxtbd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .block_format   (block_format_r),
    .push           (push),
    .full           (full),
    .in_color_block (in_color_block),
    .in_alpha_block (in_alpha_block),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  dxtbd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop),
    .empty          (empty),
    .pop            (pop),
    .out_pixel_argb (out_pixel_argb),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_last_pixel (out_last_pixel)
  );

endmodule

// ===== sv/dxtbd_checker.sv =====
// ----------------------------------------------------------------------------
// dxtbd_checker
// Port-level checks of the DXT block decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_defines.svh"

module dxtbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_pixel_argb,
  input logic [1:0]  out_pixel_row,
  input logic [1:0]  out_pixel_col,
  input logic        out_last_pixel
);

  logic [3:0] pos;

  assign pos = {out_pixel_row, out_pixel_col};

  `DXTBD_ASSERT_RST(a_reset_clears, !rst_n |=> empty && !full, "queues not empty after reset")
  `DXTBD_ASSERT(a_last_at_corner, !empty |-> out_last_pixel == (pos == 4'd15), "last flag off corner")
  `DXTBD_ASSERT(a_pixel_order, $past(rst_n) && $past(!empty && pop && !out_last_pixel) && !empty |-> pos == 4'($past(pos) + 4'd1), "pixel order broken")
  `DXTBD_ASSERT(a_stall_holds, !empty && !pop |=> !empty && $stable(out_pixel_argb), "stalled pixel changed")

endmodule

bind dxt_block_decoder dxtbd_checker u_dxtbd_checker (.*);
